### rtl/twclm_pkg.sv
// ----------------------------------------------------------------------------
// twclm_pkg
// Shared types and constants for the three-wire counter link master.
// ----------------------------------------------------------------------------
package twclm_pkg;

   localparam int CMD_BITS          = 8;
   localparam int WORD_BITS         = 32;
   localparam int DATA_BITS_DEFAULT = 32;
   localparam int REQ_FIFO_DEPTH    = 2;

   // top two command bits
   localparam logic [1:0] TOP_CLEAR = 2'b00;
   localparam logic [1:0] TOP_TRIM  = 2'b11;
   localparam int         TOP_MSB   = CMD_BITS - 1;
   localparam int         RD_FLAG   = 0;

   typedef struct packed {
      logic                 start_req;
      logic [CMD_BITS-1:0]  command;
      logic [WORD_BITS-1:0] write_data;
      logic                 data_in;
   } req_beat_type;

   typedef struct packed {
      logic                 serial_clock;
      logic                 enable_line;
      logic                 data_out;
      logic                 data_drive;
      logic [WORD_BITS-1:0] read_value;
      logic                 done_res;
      logic                 busy_res;
   } rsp_beat_type;

endpackage

### rtl/three_wire_counter_link_master.sv
// ----------------------------------------------------------------------------
// three_wire_counter_link_master
// Three-wire serial master for a counter chip, one half clock phase per beat.
// ----------------------------------------------------------------------------
// Path: request queue, then engine step into the output register (rsp_ ports).
// Throughput: one beat per cycle while the result side pops or the output
// register is empty; the engine step is the only loop carried across beats.
// Reset (synchronous, active high): queues empty, link idle, clock line high.
// ----------------------------------------------------------------------------
module three_wire_counter_link_master #(
   parameter int DATA_BITS = twclm_pkg::DATA_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // request side: one beat = one half clock phase tick
   input  logic                              push,
   output logic                              full,
   input  logic                              req_start_req,
   input  logic [twclm_pkg::CMD_BITS-1:0]    req_command,
   input  logic [twclm_pkg::WORD_BITS-1:0]   req_write_data,
   input  logic                              req_data_in,
   // result side: line levels for that tick
   output logic                              empty,
   input  logic                              pop,
   output logic                              rsp_serial_clock,
   output logic                              rsp_enable_line,
   output logic                              rsp_data_out,
   output logic                              rsp_data_drive,
   output logic [twclm_pkg::WORD_BITS-1:0]   rsp_read_value,
   output logic                              rsp_done_res,
   output logic                              rsp_busy_res
);

   localparam int REQ_W = $bits(twclm_pkg::req_beat_type);

   twclm_pkg::req_beat_type req_beat;
   twclm_pkg::req_beat_type q_beat;
   logic [REQ_W-1:0]        q_data;
   logic                    q_valid;
   logic                    q_take;
   logic                    rsp_valid;
   twclm_pkg::rsp_beat_type rsp_beat;

   // Front: gather the tick fields into one beat and park it in a short queue,
   // so the request side keeps flowing while a result waits on the rsp side.
   assign req_beat.start_req  = req_start_req;
   assign req_beat.command    = req_command;
   assign req_beat.write_data = req_write_data;
   assign req_beat.data_in    = req_data_in;

   twclm_fifo #(
      .WIDTH (REQ_W),
      .DEPTH (twclm_pkg::REQ_FIFO_DEPTH)
   ) u_req_fifo (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (push),
      .wr_data   (req_beat),
      .full      (full),
      .rd_en     (q_take),
      .not_empty (q_valid),
      .rd_data   (q_data)
   );

   assign q_beat = twclm_pkg::req_beat_type'(q_data);

   // Back: the link sequencer steps once per beat it takes and writes the
   // line levels into its output register, which forms the result queue head.
   twclm_engine #(
      .DATA_BITS (DATA_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (q_valid),
      .beat       (q_beat),
      .beat_take  (q_take),
      .rsp_valid  (rsp_valid),
      .rsp_pop    (pop),
      .rsp        (rsp_beat)
   );

   assign empty            = !rsp_valid;
   assign rsp_serial_clock = rsp_beat.serial_clock;
   assign rsp_enable_line  = rsp_beat.enable_line;
   assign rsp_data_out     = rsp_beat.data_out;
   assign rsp_data_drive   = rsp_beat.data_drive;
   assign rsp_read_value   = rsp_beat.read_value;
   assign rsp_done_res     = rsp_beat.done_res;
   assign rsp_busy_res     = rsp_beat.busy_res;

endmodule

### rtl/twclm_fifo.sv
// ----------------------------------------------------------------------------
// twclm_fifo
// Small flop-based queue between the request side and the link engine.
// ----------------------------------------------------------------------------
module twclm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic             not_empty,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign rd_data   = mem_ff[rd_ptr_ff];
   assign do_wr     = wr_en && !full;
   assign do_rd     = rd_en && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### rtl/twclm_engine.sv
// ----------------------------------------------------------------------------
// twclm_engine
// Link sequencer: one half clock phase per beat, result held in an output reg.
// ----------------------------------------------------------------------------
module twclm_engine #(
   parameter int DATA_BITS = twclm_pkg::DATA_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    beat_valid,
   input  twclm_pkg::req_beat_type beat,
   output logic                    beat_take,
   output logic                    rsp_valid,
   input  logic                    rsp_pop,
   output twclm_pkg::rsp_beat_type rsp
);

   localparam int IDX_W = $clog2(DATA_BITS);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_CMD,
      PH_READ,
      PH_WRITE,
      PH_FINISH
   } phase_type;

   phase_type                          phase_ff, phase_in;
   logic                               clk_phase_ff, clk_phase_in;
   logic [IDX_W-1:0]                   cnt_ff, cnt_in;
   logic [twclm_pkg::CMD_BITS-1:0]     cmd_ff, cmd_in;
   logic [DATA_BITS-1:0]               wdata_ff, wdata_in;
   logic [DATA_BITS-1:0]               acc_ff, acc_in;
   logic                               out_valid_ff, out_valid_in;
   twclm_pkg::rsp_beat_type            rsp_ff, rsp_in;

   logic [1:0]       cmd_top;
   logic             is_rw;
   logic             is_cmd;
   logic [IDX_W-1:0] last_idx;
   logic             tx_bit;

   assign beat_take = beat_valid && (!out_valid_ff || rsp_pop);
   assign rsp_valid = out_valid_ff;
   assign rsp       = rsp_ff;

   assign cmd_top  = cmd_ff[twclm_pkg::TOP_MSB -: 2];
   assign is_rw    = (cmd_top != twclm_pkg::TOP_CLEAR) && (cmd_top != twclm_pkg::TOP_TRIM);
   assign is_cmd   = (phase_ff == PH_CMD);
   assign last_idx = is_cmd ? IDX_W'(twclm_pkg::CMD_BITS - 1) : IDX_W'(DATA_BITS - 1);
   assign tx_bit   = is_cmd ? cmd_ff[cnt_ff[$clog2(twclm_pkg::CMD_BITS)-1:0]]
                            : wdata_ff[cnt_ff];

   always_comb begin
      phase_in     = phase_ff;
      clk_phase_in = clk_phase_ff;
      cnt_in       = cnt_ff;
      cmd_in       = cmd_ff;
      wdata_in     = wdata_ff;
      acc_in       = acc_ff;
      out_valid_in = out_valid_ff;
      rsp_in       = '0;
      rsp_in.serial_clock = 1'b1;

      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end

      case (phase_ff)
         PH_CMD, PH_WRITE: begin
            rsp_in.enable_line = 1'b1;
            rsp_in.data_drive  = 1'b1;
            rsp_in.busy_res    = 1'b1;
            rsp_in.data_out    = tx_bit;
            if (clk_phase_ff) begin
               rsp_in.serial_clock = 1'b0;
               clk_phase_in        = 1'b0;
            end else begin
               clk_phase_in = 1'b1;
               if (cnt_ff == last_idx) begin
                  cnt_in = '0;
                  if (!is_cmd || !is_rw) begin
                     phase_in = PH_FINISH;
                  end else if (cmd_ff[twclm_pkg::RD_FLAG]) begin
                     phase_in = PH_READ;
                  end else begin
                     phase_in = PH_WRITE;
                  end
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         PH_READ: begin
            rsp_in.enable_line = 1'b1;
            rsp_in.busy_res    = 1'b1;
            if (clk_phase_ff) begin
               rsp_in.serial_clock = 1'b0;
               clk_phase_in        = 1'b0;
               if (beat.data_in) begin
                  acc_in[cnt_ff] = 1'b1;
               end
            end else begin
               clk_phase_in = 1'b1;
               if (cnt_ff == IDX_W'(DATA_BITS - 1)) begin
                  cnt_in   = '0;
                  phase_in = PH_FINISH;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         PH_FINISH: begin
            rsp_in.done_res = 1'b1;
            if (is_rw && cmd_ff[twclm_pkg::RD_FLAG]) begin
               rsp_in.read_value = twclm_pkg::WORD_BITS'(acc_ff);
            end
            phase_in     = PH_IDLE;
            cnt_in       = '0;
            clk_phase_in = 1'b1;
         end
         default: begin
            phase_in     = PH_IDLE;
            clk_phase_in = 1'b1;
            if (beat.start_req) begin
               cmd_in             = beat.command;
               wdata_in           = beat.write_data[DATA_BITS-1:0];
               acc_in             = '0;
               cnt_in             = '0;
               phase_in           = PH_CMD;
               rsp_in.enable_line = 1'b1;
               rsp_in.data_drive  = 1'b1;
               rsp_in.busy_res    = 1'b1;
            end
         end
      endcase

      if (beat_take) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         clk_phase_ff <= 1'b1;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (beat_take) begin
            phase_ff     <= phase_in;
            clk_phase_ff <= clk_phase_in;
            cnt_ff       <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (beat_take) begin
         cmd_ff   <= cmd_in;
         wdata_ff <= wdata_in;
         acc_ff   <= acc_in;
         rsp_ff   <= rsp_in;
      end
   end

   // done beat never reports busy or a raised enable
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_ff.done_res) |-> (!rsp_ff.busy_res && !rsp_ff.enable_line))
      else $error("done beat with busy or enable set");

   // released data line carries no level
   a_release_low: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ff.data_drive) |-> !rsp_ff.data_out)
      else $error("data_out high while released");

   // a held result is not overwritten
   a_hold_rsp: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_pop) |=> (out_valid_ff && $stable(rsp_ff)))
      else $error("pending result changed");

   // clock goes low only while the phase moves a bit
   a_clk_low: assert property (@(posedge clock) disable iff (reset)
      (beat_take && !clk_phase_ff) |-> (phase_ff != PH_IDLE && phase_ff != PH_FINISH))
      else $error("clock low outside a bit phase");

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-wire counter link master. Every beat is
// one half clock phase tick; a local model of the link engine predicts the
// line levels of each tick, and the result side compares them field by
// field in order. Covers clear, trim, read and write transfers, start
// requests while busy, back pressure and random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINK_DATA_BITS = twclm_pkg::DATA_BITS_DEFAULT;
   localparam int CYCLE_LIMIT    = 300000;
   localparam int TAIL_CYCLES    = 12;     // settle time after the queues drain
   localparam int RANDOM_BEATS   = 200;

   // top two command bits that select a word transfer
   localparam logic [1:0] TOP_WORD_LO = 2'b01;
   localparam logic [1:0] TOP_WORD_HI = 2'b10;

   // how data_in is driven during a transfer
   localparam int DIN_LOW  = 0;
   localparam int DIN_HIGH = 1;
   localparam int DIN_RAND = 2;

   typedef enum logic [2:0] {
      LINK_IDLE   = 3'd0,
      LINK_CMD    = 3'd1,
      LINK_READ   = 3'd2,
      LINK_WRITE  = 3'd3,
      LINK_FINISH = 3'd4
   } link_phase_type;

   // ------------------------------------------------------------------------
   // DUT hookup; every input starts at a known level
   // ------------------------------------------------------------------------
   logic                            clock          = 1'b0;
   logic                            reset          = 1'b1;
   logic                            push           = 1'b0;
   logic                            pop            = 1'b0;
   logic                            req_start_req  = 1'b0;
   logic [twclm_pkg::CMD_BITS-1:0]  req_command    = '0;
   logic [twclm_pkg::WORD_BITS-1:0] req_write_data = '0;
   logic                            req_data_in    = 1'b0;
   logic                            full;
   logic                            empty;
   logic                            rsp_serial_clock;
   logic                            rsp_enable_line;
   logic                            rsp_data_out;
   logic                            rsp_data_drive;
   logic [twclm_pkg::WORD_BITS-1:0] rsp_read_value;
   logic                            rsp_done_res;
   logic                            rsp_busy_res;

   three_wire_counter_link_master #(
      .DATA_BITS(LINK_DATA_BITS)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_start_req   (req_start_req),
      .req_command     (req_command),
      .req_write_data  (req_write_data),
      .req_data_in     (req_data_in),
      .empty           (empty),
      .pop             (pop),
      .rsp_serial_clock(rsp_serial_clock),
      .rsp_enable_line (rsp_enable_line),
      .rsp_data_out    (rsp_data_out),
      .rsp_data_drive  (rsp_data_drive),
      .rsp_read_value  (rsp_read_value),
      .rsp_done_res    (rsp_done_res),
      .rsp_busy_res    (rsp_busy_res)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Shared bench state
   // ------------------------------------------------------------------------
   twclm_pkg::rsp_beat_type expected_lines[$];   // predicted line levels, oldest first
   int                      error_count      = 0;
   bit                      send_idle_on     = 1'b1;
   bit                      take_idle_on     = 1'b1;
   int                      long_hold_cycles = 0;  // set by a test, counted down below

   // Local copy of the link engine state
   link_phase_type                  lk_phase;
   logic [5:0]                      lk_bits;
   logic                            lk_clk;
   logic [twclm_pkg::CMD_BITS-1:0]  lk_cmd;
   logic [twclm_pkg::WORD_BITS-1:0] lk_wdata;
   logic [twclm_pkg::WORD_BITS-1:0] lk_rdacc;

   task automatic reset_link_state();
      lk_phase = LINK_IDLE;
      lk_bits  = '0;
      lk_clk   = 1'b1;
      lk_cmd   = '0;
      lk_wdata = '0;
      lk_rdacc = '0;
   endtask

   function automatic bit is_word_cmd(input logic [twclm_pkg::CMD_BITS-1:0] cmd);
      return cmd[twclm_pkg::TOP_MSB -: 2] == TOP_WORD_LO ||
             cmd[twclm_pkg::TOP_MSB -: 2] == TOP_WORD_HI;
   endfunction

   // Advance the engine by one tick and return the line levels for it.
   task automatic predict_line_levels(input  twclm_pkg::req_beat_type b,
                                      output twclm_pkg::rsp_beat_type r);
      logic [twclm_pkg::WORD_BITS-1:0] src;
      int                              limit;
      int                              idx;
      r              = '0;
      r.serial_clock = 1'b1;
      idx            = int'(lk_bits[4:0]);
      case (lk_phase)
         LINK_CMD, LINK_WRITE: begin
            src   = (lk_phase == LINK_CMD) ? twclm_pkg::WORD_BITS'(lk_cmd) : lk_wdata;
            limit = (lk_phase == LINK_CMD) ? twclm_pkg::CMD_BITS : LINK_DATA_BITS;
            r.enable_line = 1'b1;
            r.data_drive  = 1'b1;
            r.busy_res    = 1'b1;
            // bit stays on the line through the clock-high half too
            r.data_out    = src[idx];
            if (lk_clk) begin
               r.serial_clock = 1'b0;
               lk_clk         = 1'b0;
            end else begin
               lk_clk  = 1'b1;
               lk_bits = lk_bits + 6'd1;
               if (int'(lk_bits) >= limit) begin
                  lk_bits = '0;
                  if (lk_phase == LINK_CMD) begin
                     if (!is_word_cmd(lk_cmd))
                        lk_phase = LINK_FINISH;
                     else if (lk_cmd[twclm_pkg::RD_FLAG])
                        lk_phase = LINK_READ;
                     else
                        lk_phase = LINK_WRITE;
                  end else begin
                     lk_phase = LINK_FINISH;
                  end
               end
            end
         end
         LINK_READ: begin
            r.enable_line = 1'b1;
            r.busy_res    = 1'b1;
            if (lk_clk) begin
               r.serial_clock = 1'b0;
               lk_clk         = 1'b0;
               if (b.data_in && idx < LINK_DATA_BITS)
                  lk_rdacc[idx] = 1'b1;
            end else begin
               lk_clk  = 1'b1;
               lk_bits = lk_bits + 6'd1;
               if (int'(lk_bits) >= LINK_DATA_BITS) begin
                  lk_bits  = '0;
                  lk_phase = LINK_FINISH;
               end
            end
         end
         LINK_FINISH: begin
            r.done_res = 1'b1;
            if (is_word_cmd(lk_cmd) && lk_cmd[twclm_pkg::RD_FLAG])
               r.read_value = lk_rdacc;
            lk_phase = LINK_IDLE;
            lk_bits  = '0;
            lk_clk   = 1'b1;
         end
         default: begin
            // start is only honored here
            lk_phase = LINK_IDLE;
            lk_clk   = 1'b1;
            if (b.start_req) begin
               lk_cmd        = b.command;
               lk_wdata      = b.write_data;
               lk_rdacc      = '0;
               lk_bits       = '0;
               lk_phase      = LINK_CMD;
               r.enable_line = 1'b1;
               r.data_drive  = 1'b1;
               r.busy_res    = 1'b1;
            end
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Request side: one beat per call, with an occasional random gap first.
   // push stays high between back-to-back beats.
   // ------------------------------------------------------------------------
   task automatic send_tick(input logic start,
                            input logic [twclm_pkg::CMD_BITS-1:0] cmd,
                            input logic [twclm_pkg::WORD_BITS-1:0] wdata,
                            input logic din);
      twclm_pkg::req_beat_type beat;
      twclm_pkg::rsp_beat_type line;
      int                      gap;
      beat.start_req  = start;
      beat.command    = cmd;
      beat.write_data = wdata;
      beat.data_in    = din;
      if (send_idle_on && $urandom_range(0, 11) == 0) begin
         gap = $urandom_range(1, 13);
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push           <= 1'b1;
      req_start_req  <= start;
      req_command    <= cmd;
      req_write_data <= wdata;
      req_data_in    <= din;
      do @(posedge clock); while (full);
      predict_line_levels(beat, line);
      expected_lines.push_back(line);
   endtask

   // Sender stops and waits until every predicted beat has come back.
   task automatic wait_drained();
      push <= 1'b0;
      while (expected_lines.size() != 0) @(posedge clock);
   endtask

   function automatic logic [twclm_pkg::CMD_BITS-1:0] pick_command();
      logic [1:0] top;
      case ($urandom_range(0, 3))
         0:       top = twclm_pkg::TOP_CLEAR;
         1:       top = twclm_pkg::TOP_TRIM;
         2:       top = TOP_WORD_LO;
         default: top = TOP_WORD_HI;
      endcase
      return {top, 6'($urandom)};
   endfunction

   function automatic logic din_level(input int din_mode);
      if (din_mode == DIN_RAND)
         return 1'($urandom);
      return din_mode == DIN_HIGH;
   endfunction

   // One well-formed transfer: start tick, command, optional word, finish.
   // With noisy set, start is toggled at random while busy (must be ignored)
   // and the other fields carry junk. Up to two idle ticks with junk fields follow.
   task automatic run_transfer(input logic [twclm_pkg::CMD_BITS-1:0] cmd,
                               input logic [twclm_pkg::WORD_BITS-1:0] wdata,
                               input int din_mode, input bit noisy,
                               inout int beats);
      int len;
      int idle_ticks;
      len = 2 + 2 * twclm_pkg::CMD_BITS + (is_word_cmd(cmd) ? 2 * LINK_DATA_BITS : 0);
      send_tick(1'b1, cmd, wdata, din_level(din_mode));
      for (int i = 1; i < len; i++)
         send_tick(noisy ? 1'($urandom) : 1'b0,
                   noisy ? twclm_pkg::CMD_BITS'($urandom) : cmd,
                   noisy ? $urandom : wdata,
                   din_level(din_mode));
      beats += len;
      idle_ticks = $urandom_range(0, 2);
      repeat (idle_ticks)
         send_tick(1'b0, twclm_pkg::CMD_BITS'($urandom), $urandom, 1'($urandom));
   endtask

   task automatic run_random_transfer(input bit noisy, inout int beats);
      int din_mode;
      case ($urandom_range(0, 5))
         0:       din_mode = DIN_LOW;
         1:       din_mode = DIN_HIGH;
         default: din_mode = DIN_RAND;
      endcase
      run_transfer(pick_command(), $urandom, din_mode, noisy, beats);
   endtask

   // ------------------------------------------------------------------------
   // Result side: random stall bursts, a long hold on request, and the check
   // of every beat taken against the oldest prediction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_side
      twclm_pkg::rsp_beat_type seen;
      twclm_pkg::rsp_beat_type want;
      int                      stall_left;
      if (reset) begin
         pop        <= 1'b0;
         stall_left = 0;
      end else begin
         if (pop && !empty) begin
            seen.serial_clock = rsp_serial_clock;
            seen.enable_line  = rsp_enable_line;
            seen.data_out     = rsp_data_out;
            seen.data_drive   = rsp_data_drive;
            seen.read_value   = rsp_read_value;
            seen.done_res     = rsp_done_res;
            seen.busy_res     = rsp_busy_res;
            if (expected_lines.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: result beat with nothing predicted: %p", $realtime, seen);
            end else begin
               want = expected_lines.pop_front();
               if (seen.serial_clock !== want.serial_clock ||
                   seen.enable_line  !== want.enable_line  ||
                   seen.data_out     !== want.data_out     ||
                   seen.data_drive   !== want.data_drive   ||
                   seen.read_value   !== want.read_value   ||
                   seen.done_res     !== want.done_res     ||
                   seen.busy_res     !== want.busy_res) begin
                  error_count++;
                  // fields: sclk en dout drv rd done busy
                  if (error_count <= 10)
                     $display("%0t: mismatch exp %b %b %b %b %h %b %b act %b %b %b %b %h %b %b",
                              $realtime,
                              want.serial_clock, want.enable_line, want.data_out,
                              want.data_drive, want.read_value, want.done_res,
                              want.busy_res,
                              seen.serial_clock, seen.enable_line, seen.data_out,
                              seen.data_drive, seen.read_value, seen.done_res,
                              seen.busy_res);
               end
            end
         end
         // next cycle's pop
         if (long_hold_cycles > 0) begin
            long_hold_cycles--;
            pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
         end else if (take_idle_on && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Idle ticks with junk, then a clear with start held high the whole way,
   // finishing tick included. Field extremes on command and write data.
   task automatic test_clear_directed();
      int beats;
      beats = 0;
      send_tick(1'b0, '1, '1, 1'b1);
      send_tick(1'b0, '0, '0, 1'b0);
      send_tick(1'b1, {twclm_pkg::TOP_CLEAR, 6'd0}, '1, 1'b1);
      for (int i = 1; i < 2 + 2 * twclm_pkg::CMD_BITS; i++)
         send_tick(1'b1, '1, (i % 2) ? '0 : '1, 1'(i % 2));
      beats += 2 + 2 * twclm_pkg::CMD_BITS;
   endtask

   // Trim, a read and a write at the extremes, then random transfers.
   task automatic test_random_transfers();
      int beats;
      beats = 0;
      run_transfer({twclm_pkg::TOP_TRIM, 6'h3F}, '0, DIN_LOW, 1'b1, beats);
      run_transfer({TOP_WORD_HI, 6'h00}, '1, DIN_HIGH, 1'b1, beats);
      run_transfer({TOP_WORD_LO, 6'h3F}, '1, DIN_HIGH, 1'b1, beats);
      while (beats < RANDOM_BEATS)
         run_random_transfer($urandom_range(0, 3) != 0, beats);
   endtask

   // Result side holds off long enough for the queues to fill while a full
   // read transfer is being offered, so full must rise and hold the sender.
   task automatic test_fill_stall();
      int beats;
      beats = 0;
      send_idle_on     = 1'b0;
      long_hold_cycles = 120;
      run_transfer({TOP_WORD_HI, 6'($urandom) | 6'h01}, $urandom, DIN_RAND, 1'b1, beats);
      send_idle_on     = 1'b1;
   endtask

   // Sender goes quiet until every beat is back, then resumes.
   task automatic test_drain_pause();
      int beats;
      beats = 0;
      run_transfer({TOP_WORD_LO, 6'($urandom) & 6'h3E}, $urandom, DIN_RAND, 1'b0, beats);
      wait_drained();
      run_transfer({twclm_pkg::TOP_TRIM, 6'($urandom)}, $urandom, DIN_RAND, 1'b1, beats);
      wait_drained();
   endtask

   // Last stretch at full rate on both sides.
   task automatic test_steady_tail();
      int beats;
      beats = 0;
      send_idle_on = 1'b0;
      take_idle_on = 1'b0;
      repeat (2) run_random_transfer(1'b1, beats);
   endtask

   // ------------------------------------------------------------------------
   // Run-time guard
   // ------------------------------------------------------------------------
   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top: done, errors");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset_link_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_clear_directed();
      test_random_transfers();
      test_fill_stall();
      test_drain_pause();
      test_steady_tail();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      error_count += expected_lines.size();
      if (error_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
